/* rtl/core/b64e_pkg.sv */
`default_nettype none
package b64e_pkg;

   localparam logic [15:0] CAP_RESET           = 16'hFFFF;
   localparam int          QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [2:0] NCHARS_NONE  = 3'd0;
   localparam logic [2:0] NCHARS_TWO   = 3'd2;
   localparam logic [2:0] NCHARS_THREE = 3'd3;
   localparam logic [2:0] NCHARS_FULL  = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        char_valid;
      logic        last_of_message;
      logic [15:0] total_chars;
   } rsp_type;

   typedef struct packed {
      logic [23:0] group;
      logic [2:0]  nchars;
      logic        last;
      logic [15:0] total;
   } cmd_type;

   function automatic logic [7:0] alpha_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26)
         return 8'h41 + wide;
      else if (idx < 6'd52)
         return 8'h61 + wide - 8'd26;
      else if (idx < 6'd62)
         return 8'h30 + wide - 8'd52;
      else if (idx == 6'd62)
         return 8'h2D;
      else
         return 8'h5F;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/base64url_encoder_unit.sv */
// base64url encoder, unpadded
// req channel: one message byte per beat, message_end on the final byte of a message.
// rsp channel: one base64url character per beat; the final beat of a message carries
// last_of_message and total_chars, and a message that yields no character gives one
// dataless beat (char_valid low) as its end marker.
// csr_wr_en/csr_wr_data write the output capacity; write only while the block is idle.
// a closed group is registered in the queue, then in cmd_ff, then in the rsp_ff output.
// throughput: one result beat per cycle unless rsp stalls, set by the single character
// output stage; a full group of three bytes yields four characters.
// the front end keeps the group state and capacity check and hands group commands to
// the back end through a short queue; the front stalls req only when that queue is full.
// reset clears the open group, the counts and the queue and sets the capacity to 65535.
// a stalled rsp beat holds; the back end waits and the queue then fills and stalls req.
`default_nettype none
module base64url_encoder_unit #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  b64e_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output b64e_pkg::rsp_type     rsp_data,
   input  wire                   csr_wr_en,
   input  wire  [15:0]           csr_wr_data
);
   import b64e_pkg::*;

   logic    q_not_full;
   logic    q_not_empty;
   logic    q_push;
   logic    q_pop;
   cmd_type q_cmd;
   cmd_type q_head;

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_not_full  (q_not_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/core/b64e_queue.sv */
`default_nettype none
module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  b64e_pkg::cmd_type     push_cmd,
   output logic                  not_full,
   input  wire                   pop,
   output logic                  not_empty,
   output b64e_pkg::cmd_type     head_cmd
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_cmd;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count not reduced on pop");

   a_push_moves: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count not raised on push");

endmodule
`default_nettype wire

/* rtl/core/b64e_front.sv */
`default_nettype none
module b64e_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  b64e_pkg::req_type     req_data,
   input  wire                   csr_wr_en,
   input  wire  [15:0]           csr_wr_data,
   input  wire                   q_not_full,
   output logic                  q_push,
   output b64e_pkg::cmd_type     q_cmd
);
   import b64e_pkg::*;

   logic [15:0] cap_ff;
   logic [15:0] held_ff, held_in;
   logic [1:0]  hc_ff, hc_in;
   logic [15:0] em_ff, em_in;
   logic        stop_ff, stop_in;
   logic [2:0]  nchars, nchars_eff;
   logic [23:0] grp;
   logic [16:0] sum;
   logic        fits;
   logic        accept;

   assign req_stall = !q_not_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_in    = held_ff;
      hc_in      = hc_ff;
      em_in      = em_ff;
      stop_in    = stop_ff;
      nchars     = NCHARS_NONE;
      grp        = '0;
      if (!stop_ff) begin
         if (hc_ff == 2'd2) begin
            grp     = {held_ff, req_data.in_byte};
            nchars  = NCHARS_FULL;
            held_in = '0;
            hc_in   = 2'd0;
         end else begin
            held_in = {held_ff[7:0], req_data.in_byte};
            hc_in   = hc_ff + 2'd1;
            if (req_data.message_end) begin
               if (hc_ff == 2'd0) begin
                  grp    = {req_data.in_byte, 16'h0000};
                  nchars = NCHARS_TWO;
               end else begin
                  grp    = {held_ff[7:0], req_data.in_byte, 8'h00};
                  nchars = NCHARS_THREE;
               end
            end
         end
      end
      sum        = {1'b0, em_ff} + {14'd0, nchars};
      fits       = sum < {1'b0, cap_ff};
      nchars_eff = nchars;
      if (nchars != NCHARS_NONE) begin
         if (fits) begin
            em_in = sum[15:0];
         end else begin
            stop_in    = 1'b1;
            nchars_eff = NCHARS_NONE;
         end
      end
      q_cmd.group  = grp;
      q_cmd.nchars = nchars_eff;
      q_cmd.last   = req_data.message_end;
      q_cmd.total  = em_in;
      q_push       = accept && (nchars_eff != NCHARS_NONE || req_data.message_end);
      if (req_data.message_end) begin
         held_in = '0;
         hc_in   = 2'd0;
         em_in   = '0;
         stop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         held_ff <= '0;
         hc_ff   <= '0;
         em_ff   <= '0;
         stop_ff <= 1'b0;
      end else begin
         if (csr_wr_en)
            cap_ff <= csr_wr_data;
         if (accept) begin
            held_ff <= held_in;
            hc_ff   <= hc_in;
            em_ff   <= em_in;
            stop_ff <= stop_in;
         end
      end
   end

   a_hc_range: assert property (@(posedge clock) disable iff (reset)
      hc_ff != 2'd3)
      else $error("held byte count out of range");

   a_em_below_cap: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.nchars != NCHARS_NONE |-> {1'b0, q_cmd.total} < {1'b0, cap_ff})
      else $error("emitted group overruns capacity");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.message_end |=> hc_ff == 2'd0 && em_ff == '0 && !stop_ff)
      else $error("message state not cleared at end");

endmodule
`default_nettype wire

/* rtl/core/b64e_back.sv */
`default_nettype none
module b64e_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_not_empty,
   input  b64e_pkg::cmd_type     q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output b64e_pkg::rsp_type     rsp_data
);
   import b64e_pkg::*;

   cmd_type     cmd_ff;
   logic        busy_ff, busy_in;
   logic [1:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        out_free;
   logic        emit;
   logic        is_final;
   logic [5:0]  slice;
   logic        has_char;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign has_char  = (cmd_ff.nchars != NCHARS_NONE);
   assign is_final  = !has_char || ({1'b0, pos_ff} == cmd_ff.nchars - 3'd1);
   assign q_pop     = q_not_empty && (!busy_ff || (emit && is_final));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (pos_ff)
         2'd0:    slice = cmd_ff.group[23:18];
         2'd1:    slice = cmd_ff.group[17:12];
         2'd2:    slice = cmd_ff.group[11:6];
         default: slice = cmd_ff.group[5:0];
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free)
         rsp_valid_in = 1'b0;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_in.char_valid      = has_char;
         rsp_in.out_char        = has_char ? alpha_char(slice) : 8'h00;
         rsp_in.last_of_message = is_final && cmd_ff.last;
         rsp_in.total_chars     = (is_final && cmd_ff.last) ? cmd_ff.total : 16'h0000;
         if (is_final)
            busy_in = 1'b0;
         else
            pos_in = pos_ff + 2'd1;
      end
      if (q_pop) begin
         busy_in = 1'b1;
         pos_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (q_pop)
         cmd_ff <= q_head;
   end

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.char_valid |-> rsp_ff.last_of_message)
      else $error("dataless beat without end flag");

   a_total_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_of_message |-> rsp_ff.total_chars == 16'h0000)
      else $error("count on a beat that is not last");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && has_char |-> {1'b0, pos_ff} < cmd_ff.nchars)
      else $error("character index past group size");

endmodule
`default_nettype wire
